// ----- src/cci_pkg.sv -----
// Package: shared widths, constants and transaction types for the channel index block.
`timescale 1ns / 1ps
package cci_pkg;

	localparam int PERIOD_W = 7;
	localparam int PRICE_W  = 32;
	localparam int SUM_W    = 39;
	localparam int DEV_W    = 46;
	localparam int DEN_W    = 48;
	localparam int PROD_W   = 54;
	localparam int FRAC_W   = 16;
	localparam int NUM_W    = PROD_W + FRAC_W;
	localparam int SCALE_W  = 15;

	// 1 / 0.015 = 200 / 3
	localparam int K_SCALE  = 200;
	localparam int TYP_DIV  = 3;

	// divide by three on 18-bit chunks: q = (y * DIV3_M) >> DIV3_SH
	localparam int DIV3_W   = 18;
	localparam int DIV3_SH  = 20;
	localparam int DIV3_M   = ((1 << DIV3_SH) + 2) / TYP_DIV;
	localparam int DIV3_PW  = 2 * DIV3_W + 2;

	typedef struct packed {
		logic [PRICE_W-1:0] high_price;
		logic [PRICE_W-1:0] low_price;
		logic [PRICE_W-1:0] close_price;
		logic               restart;
	} bar_t;

	typedef struct packed {
		logic signed [31:0] cci_value;
		logic               flat_window;
		logic               saturated;
	} cci_t;

endpackage

// ----- src/cci_cell.sv -----
// One window slot: holds a typical price and passes it to the next slot.
`timescale 1ns / 1ps
`default_nettype none
module cci_cell (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [cci_pkg::PRICE_W-1:0] d,
	output logic      [cci_pkg::PRICE_W-1:0] q
);
	import cci_pkg::*;

	logic [PRICE_W-1:0] val_q;

	// load from neighbor on every advance
	always_ff @(posedge clk) begin
		if (en) begin
			val_q <= d;
		end
	end

	assign q = val_q;

endmodule
`default_nettype wire

// ----- src/cci_ring.sv -----
// Chain of window cells: insert a new price at the head or rotate the tail back in.
`timescale 1ns / 1ps
`default_nettype none
module cci_ring #(
	parameter int DEPTH = 64
) (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic                        load_new,
	input  wire logic [cci_pkg::PRICE_W-1:0] new_val,
	output logic      [cci_pkg::PRICE_W-1:0] tail
);
	import cci_pkg::*;

	logic [PRICE_W-1:0] link [DEPTH+1];

	// head takes the new price or the recirculated tail
	assign link[0] = load_new ? new_val : link[DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cci_cell u_cell (
			.clk (clk),
			.en  (en),
			.d   (link[i]),
			.q   (link[i+1])
		);
	end

	assign tail = link[DEPTH];

endmodule
`default_nettype wire

// ----- src/cci_div.sv -----
// Restoring divider, one quotient bit per cycle, rounded to nearest at the end.
`timescale 1ns / 1ps
`default_nettype none
module cci_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      go,
	input  wire logic [cci_pkg::NUM_W-1:0] num,
	input  wire logic [cci_pkg::DEN_W-1:0] den,
	output logic                           done,
	output logic      [cci_pkg::NUM_W:0]   quo
);
	import cci_pkg::*;

	localparam int CW = $clog2(NUM_W + 1);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic [NUM_W-1:0] n_q;
	logic [NUM_W-1:0] q_q;
	logic [DEN_W-1:0] d_q;
	logic [DEN_W-1:0] r_q;
	logic [DEN_W:0]   r_sh;
	logic             ge;

	// trial subtract
	assign r_sh = {r_q, n_q[NUM_W-1]};
	assign ge   = r_sh >= {1'b0, d_q};

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (go) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			n_q <= n_q << 1;
			r_q <= ge ? DEN_W'(r_sh - {1'b0, d_q}) : DEN_W'(r_sh);
			q_q <= {q_q[NUM_W-2:0], ge};
		end
	end

	// round half up on the final remainder
	assign quo  = {1'b0, q_q} + (NUM_W+1)'({r_q, 1'b0} >= {1'b0, d_q});
	assign done = done_q;

endmodule
`default_nettype wire

// ----- src/commodity_channel_index.sv -----
// Top level: commodity channel index over a ring of price cells and a serial divider.
//
// Usage: one price bar per transaction on the bar channel (bar_valid / bar_stall),
// at most one result per bar on the cci channel (cci_valid / cci_stall). The period
// register is written on the cfg channel (cfg_valid / cfg_ready); a write restarts
// the series, is taken only while idle and holds off the bar channel while it waits.
// A bar with restart set begins a new series.
// Each bar forms the typical price in states TDIV and TLO (reciprocal multiply on two
// 18-bit halves), inserts it and then scans the whole cell ring; without a result the
// next bar can be taken once the scan ends. A bar with a result then forms the
// numerator and the divider operands and runs a 70-step divider pass with its start
// and finish before the result shows, and the next bar can be taken once it shows;
// a flat window skips the divider. One bar is in flight at a time: a new bar waits
// until the last one is through.
// No result appears until 2*period-2 earlier bars of the series were seen.
// Reset restores period 20 and clears the series; the window cells hold no
// reset value and are only read after being written in the current series.
// While cci_stall is high the finished result waits in the output register and
// the next bar is still taken; a later result waits until that register frees.
`timescale 1ns / 1ps
`default_nettype none
module commodity_channel_index #(
	parameter int MAX_PERIOD = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         bar_valid,
	output logic                              bar_stall,
	input  wire cci_pkg::bar_t                bar,
	output logic                              cci_valid,
	input  wire logic                         cci_stall,
	output cci_pkg::cci_t                     cci,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [cci_pkg::PERIOD_W-1:0] cfg_data
);
	import cci_pkg::*;

	localparam int BW = $clog2(2 * MAX_PERIOD + 1);
	localparam int JW = $clog2(MAX_PERIOD + 1);
	localparam int SW = 4;

	localparam logic [SW-1:0] ST_IDLE = 4'd0;
	localparam logic [SW-1:0] ST_TDIV = 4'd1;
	localparam logic [SW-1:0] ST_INS  = 4'd2;
	localparam logic [SW-1:0] ST_SCAN = 4'd3;
	localparam logic [SW-1:0] ST_NUM  = 4'd4;
	localparam logic [SW-1:0] ST_MUL  = 4'd5;
	localparam logic [SW-1:0] ST_CDIV = 4'd6;
	localparam logic [SW-1:0] ST_RES  = 4'd7;
	localparam logic [SW-1:0] ST_TLO  = 4'd8;

	logic [SW-1:0]       state_q;
	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] p_eff;
	logic [BW-1:0]       bars_q;
	logic [BW-1:0]       bars_base;
	logic [SUM_W-1:0]    sum_q;
	logic                emit_q;
	logic                sub_q;
	logic                neg_q;
	logic                flat_q;
	logic [JW-1:0]       scan_q;
	logic [PRICE_W-1:0]  t_q;
	logic [SUM_W-1:0]    pt_q;
	logic [SUM_W-1:0]    num_q;
	logic [DEV_W-1:0]    dev_q;
	logic [NUM_W:0]      mag_q;

	logic [SUM_W-1:0]    px_s1;
	logic [PRICE_W-1:0]  x_s1;
	logic                acc_s1;
	logic                cap_s1;
	logic                v_s1;

	logic [NUM_W-1:0]    div_num_q;
	logic [DEN_W-1:0]    div_den_q;
	logic                div_go_q;
	logic                div_done;
	logic [NUM_W:0]      div_quo;

	logic [PRICE_W+1:0]  y_q;
	logic [15:0]         qh_q;
	logic [1:0]          rem_q;
	logic [DIV3_W-1:0]   div3_in;
	logic [DIV3_PW-1:0]  div3_prod;
	logic [DIV3_W-1:0]   div3_quo;
	logic [1:0]          div3_rem;

	logic                ring_en;
	logic                ring_load;
	logic [PRICE_W-1:0]  ring_tail;

	logic                bar_acc;
	logic                cfg_acc;
	logic                out_free;
	logic                rotating;
	logic [SUM_W-1:0]    absdiff;
	logic [SCALE_W-1:0]  p200;
	logic [PRICE_W+1:0]  s3;
	cci_t                res;
	logic                cci_valid_q;
	cci_t                cci_q;

	// clamp the period into 1..MAX_PERIOD
	always_comb begin
		if (period_q == '0) begin
			p_eff = PERIOD_W'(1);
		end else if (16'(period_q) > 16'(MAX_PERIOD)) begin
			p_eff = PERIOD_W'(MAX_PERIOD);
		end else begin
			p_eff = period_q;
		end
	end

	assign bar_stall = (state_q != ST_IDLE) || cfg_valid;
	assign bar_acc   = bar_valid && !bar_stall;
	assign cfg_ready = (state_q == ST_IDLE);
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign out_free  = !cci_valid_q || !cci_stall;
	assign bars_base = bar.restart ? '0 : bars_q;
	assign s3        = (PRICE_W+2)'(bar.high_price) + (PRICE_W+2)'(bar.low_price)
		+ (PRICE_W+2)'(bar.close_price);
	assign rotating  = (state_q == ST_SCAN) && (16'(scan_q) < 16'(MAX_PERIOD));
	assign ring_en   = rotating || (state_q == ST_INS);
	assign ring_load = (state_q == ST_INS);
	assign absdiff   = (px_s1 > sum_q) ? px_s1 - sum_q : sum_q - px_s1;
	assign p200      = SCALE_W'(p_eff) * SCALE_W'(K_SCALE);

	// divide by three: high half first, then remainder joined with the low half
	assign div3_in   = (state_q == ST_TDIV) ? y_q[PRICE_W+1:16] : {rem_q, y_q[15:0]};
	assign div3_prod = DIV3_PW'(div3_in) * DIV3_PW'(DIV3_M);
	assign div3_quo  = div3_prod[DIV3_SH +: DIV3_W];
	assign div3_rem  = 2'(div3_in - ((div3_quo << 1) + div3_quo));

	cci_ring #(
		.DEPTH (MAX_PERIOD)
	) u_ring (
		.clk      (clk),
		.en       (ring_en),
		.load_new (ring_load),
		.new_val  (t_q),
		.tail     (ring_tail)
	);

	cci_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go_q),
		.num    (div_num_q),
		.den    (div_den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// saturate and sign the final magnitude
	always_comb begin
		res = '0;
		if (flat_q) begin
			res.flat_window = 1'b1;
		end else if (!neg_q) begin
			if (mag_q > (NUM_W+1)'(32'h7FFF_FFFF)) begin
				res.cci_value = 32'sh7FFF_FFFF;
				res.saturated = 1'b1;
			end else begin
				res.cci_value = mag_q[31:0];
			end
		end else begin
			if (mag_q > (NUM_W+1)'(32'h8000_0000)) begin
				res.cci_value = 32'sh8000_0000;
				res.saturated = 1'b1;
			end else begin
				res.cci_value = 32'(~mag_q[31:0] + 32'd1);
			end
		end
	end

	// sequencer and series state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			period_q    <= PERIOD_W'(20);
			bars_q      <= '0;
			sum_q       <= '0;
			scan_q      <= '0;
			v_s1        <= 1'b0;
			div_go_q    <= 1'b0;
			cci_valid_q <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			if (cci_valid_q && !cci_stall) begin
				cci_valid_q <= 1'b0;
			end
			v_s1 <= rotating;
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_acc) begin
						period_q <= cfg_data;
						bars_q   <= '0;
						sum_q    <= '0;
					end else if (bar_acc) begin
						if (bar.restart) begin
							sum_q <= '0;
						end
						if (16'(bars_base) < 16'(2 * MAX_PERIOD)) begin
							bars_q <= bars_base + 1'b1;
						end else begin
							bars_q <= bars_base;
						end
						state_q <= ST_TDIV;
					end
				end
				ST_TDIV: begin
					state_q <= ST_TLO;
				end
				ST_TLO: begin
					state_q <= ST_INS;
				end
				ST_INS: begin
					// add the new price; at full depth the oldest drops off the tail
					if (sub_q && (16'(p_eff) == 16'(MAX_PERIOD))) begin
						sum_q <= sum_q + SUM_W'(t_q) - SUM_W'(ring_tail);
					end else begin
						sum_q <= sum_q + SUM_W'(t_q);
					end
					scan_q  <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					// drop the oldest price as it passes the tail
					if (v_s1 && cap_s1) begin
						sum_q <= sum_q - SUM_W'(x_s1);
					end
					if (rotating) begin
						scan_q <= scan_q + 1'b1;
					end else begin
						state_q <= emit_q ? ST_NUM : ST_IDLE;
					end
				end
				ST_NUM: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					div_go_q <= (dev_q != '0);
					state_q  <= (dev_q == '0) ? ST_RES : ST_CDIV;
				end
				ST_CDIV: begin
					if (div_done) begin
						state_q <= ST_RES;
					end
				end
				ST_RES: begin
					if (out_free) begin
						cci_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// per-bar datapath registers
	always_ff @(posedge clk) begin
		if (bar_acc) begin
			emit_q <= 16'(bars_base) >= ((16'(p_eff) << 1) - 16'd2);
			sub_q  <= 16'(bars_base) >= 16'(p_eff);
			y_q    <= s3 + (PRICE_W+2)'(1);
		end
		// typical price, rounded to nearest
		if (state_q == ST_TDIV) begin
			qh_q  <= div3_quo[15:0];
			rem_q <= div3_rem;
		end
		if (state_q == ST_TLO) begin
			t_q <= {qh_q, div3_quo[15:0]};
		end
		if (state_q == ST_INS) begin
			pt_q  <= SUM_W'(p_eff) * SUM_W'(t_q);
			dev_q <= '0;
		end
		// scan stage 1: scale the tail price
		if (rotating) begin
			px_s1  <= SUM_W'(p_eff) * SUM_W'(ring_tail);
			x_s1   <= ring_tail;
			acc_s1 <= 16'(scan_q) >= (16'(MAX_PERIOD) - 16'(p_eff));
			cap_s1 <= sub_q && (16'(scan_q) + 16'(p_eff) + 16'd1 == 16'(MAX_PERIOD));
		end
		// scan stage 2: accumulate absolute deviation
		if (state_q == ST_SCAN && v_s1 && acc_s1) begin
			dev_q <= dev_q + DEV_W'(absdiff);
		end
		if (state_q == ST_NUM) begin
			neg_q <= pt_q < sum_q;
			num_q <= (pt_q < sum_q) ? sum_q - pt_q : pt_q - sum_q;
		end
		if (state_q == ST_MUL) begin
			flat_q    <= (dev_q == '0);
			div_num_q <= {PROD_W'(num_q) * PROD_W'(p200), FRAC_W'(0)};
			div_den_q <= (DEN_W'(dev_q) << 1) + DEN_W'(dev_q);
		end
		if (state_q == ST_CDIV && div_done) begin
			mag_q <= div_quo;
		end
		if (state_q == ST_RES && out_free) begin
			cci_q <= res;
		end
	end

	assign cci_valid = cci_valid_q;
	assign cci       = cci_q;

	// a flat window always reports zero and no clamp
	assert property (@(posedge clk) disable iff (!arst_n)
		cci_valid && cci.flat_window |-> cci.cci_value == '0 && !cci.saturated)
		else $error("flat window result not zero");

	// a clamped result sits at one of the limits
	assert property (@(posedge clk) disable iff (!arst_n)
		cci_valid && cci.saturated |->
		cci.cci_value == 32'sh7FFF_FFFF || cci.cci_value == 32'sh8000_0000)
		else $error("saturated result off the limits");

	// the bar count never passes its ceiling
	assert property (@(posedge clk) disable iff (!arst_n)
		16'(bars_q) <= 16'(2 * MAX_PERIOD))
		else $error("bar count past ceiling");

	// the scan never runs past the ring depth
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> 16'(scan_q) <= 16'(MAX_PERIOD))
		else $error("scan counter out of range");

	// an accepted bar always starts the typical price step
	assert property (@(posedge clk) disable iff (!arst_n)
		bar_acc |=> state_q == ST_TDIV)
		else $error("bar accepted without typical price step");

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Testbench for the commodity channel index block: self-checking, with a predictor and scoreboard.
`timescale 1ns / 1ps
module tb_top;
	import cci_pkg::*;

	localparam int MAXP = 64;
	localparam int LAT = 300;
	localparam int WATCH_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic bar_valid = 1'b0;
	logic bar_stall;
	bar_t bar = '0;
	logic cci_valid;
	logic cci_stall = 1'b0;
	cci_t cci;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [PERIOD_W-1:0] cfg_data = '0;

	commodity_channel_index #(.MAX_PERIOD(MAXP)) dut (
		.clk(clk), .arst_n(arst_n),
		.bar_valid(bar_valid), .bar_stall(bar_stall), .bar(bar),
		.cci_valid(cci_valid), .cci_stall(cci_stall), .cci(cci),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// Predictor state
	logic [PERIOD_W-1:0] cur_period;
	logic [31:0] typ_ring [MAXP];
	logic [63:0] ring_sum;
	int unsigned ring_slot;
	int unsigned series_len;

	bar_t bar_queue[$];
	cci_t cci_expected[$];
	int unsigned errors = 0;
	int unsigned bars_sent = 0;
	int unsigned results_seen = 0;
	int unsigned flat_seen = 0;
	int unsigned sat_seen = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_off = 0;
	int unsigned quiet_cycles = 0;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		errors++;
	endtask

	function automatic int unsigned active_period();
		if (cur_period == 0) return 1;
		if (cur_period > MAXP) return MAXP;
		return cur_period;
	endfunction

	function automatic void restart_series();
		ring_sum = 0;
		ring_slot = 0;
		series_len = 0;
	endfunction

	// Predict the channel index for one bar; push the result when one is due
	function automatic void predict_cci(input bar_t b);
		int unsigned p;
		logic [33:0] s3;
		logic [63:0] tp, pt, num, dev, px, den;
		logic [127:0] prod, mag;
		logic neg;
		cci_t r;
		p = active_period();
		s3 = 34'(b.high_price) + 34'(b.low_price) + 34'(b.close_price);
		tp = 64'((s3 + 34'd1) / 34'd3);
		if (b.restart) restart_series();
		if (ring_slot >= p) ring_slot = 0;
		if (series_len >= p) ring_sum -= 64'(typ_ring[ring_slot]);
		typ_ring[ring_slot] = tp[31:0];
		ring_sum += tp;
		ring_slot = (ring_slot + 1 >= p) ? 0 : ring_slot + 1;
		if (series_len < 2 * p - 2) begin
			if (series_len < 2 * MAXP) series_len++;
			return;
		end
		if (series_len < 2 * MAXP) series_len++;
		pt = 64'(p) * tp;
		neg = pt < ring_sum;
		num = neg ? ring_sum - pt : pt - ring_sum;
		dev = 0;
		for (int j = 0; j < p; j++) begin
			px = 64'(p) * 64'(typ_ring[j]);
			dev += (px > ring_sum) ? px - ring_sum : ring_sum - px;
		end
		r = '0;
		if (dev == 0) begin
			r.flat_window = 1'b1;
		end else begin
			prod = 128'(num) * 128'(64'(p) * 64'd200 * 64'd65536);
			den = 3 * dev;
			mag = prod / 128'(den);
			if ((prod % 128'(den)) * 2 >= 128'(den)) mag += 1;
			if (!neg) begin
				if (mag > 128'h7FFF_FFFF) begin
					mag = 128'h7FFF_FFFF;
					r.saturated = 1'b1;
				end
				r.cci_value = mag[31:0];
			end else begin
				if (mag > 128'h8000_0000) begin
					mag = 128'h8000_0000;
					r.saturated = 1'b1;
				end
				r.cci_value = 32'(0) - mag[31:0];
			end
		end
		cci_expected.push_back(r);
	endfunction

	// Driver: offer queued bars; predict on acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (bar_valid && !bar_stall) begin
				predict_cci(bar);
				bars_sent++;
			end
			if (!bar_valid || !bar_stall) begin
				if (bar_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					bar_valid <= 1'b1;
					bar <= bar_queue.pop_front();
				end else begin
					bar_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_off > 0) begin
			cci_stall <= 1'b1;
			hold_off <= hold_off - 1;
		end else begin
			cci_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		cci_t want;
		if (arst_n && cci_valid && !cci_stall) begin
			results_seen++;
			if (cci_expected.size() == 0) begin
				report("unexpected result", cci.cci_value, 32'h0);
			end else begin
				want = cci_expected.pop_front();
				if (cci.cci_value !== want.cci_value)
					report("cci_value", cci.cci_value, want.cci_value);
				if (cci.flat_window !== want.flat_window)
					report("flat_window", 32'(cci.flat_window), 32'(want.flat_window));
				if (cci.saturated !== want.saturated)
					report("saturated", 32'(cci.saturated), 32'(want.saturated));
				flat_seen += want.flat_window;
				sat_seen += want.saturated;
			end
		end
	end

	// Watchdog: count cycles with no transaction
	always @(posedge clk) begin
		if ((bar_valid && !bar_stall) || (cci_valid && !cci_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [31:0] rand_price();
		case ($urandom_range(5))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return 32'h0064_0000 + $urandom_range(32'h0004_0000);
		endcase
	endfunction

	function automatic bar_t make_bar(input logic [31:0] h, input logic [31:0] l,
			input logic [31:0] c, input logic rs);
		bar_t b;
		b.high_price = h;
		b.low_price = l;
		b.close_price = c;
		b.restart = rs;
		return b;
	endfunction

	task automatic drain();
		while (bar_queue.size() > 0 || bar_valid || cci_expected.size() > 0)
			@(posedge clk);
		repeat (LAT) @(posedge clk);
	endtask

	task automatic write_period(input int unsigned p);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= p[PERIOD_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cur_period = p[PERIOD_W-1:0];
		restart_series();
		cfg_valid <= 1'b0;
	endtask

	task automatic random_bars(input int unsigned n);
		logic [31:0] base;
		base = $urandom;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0)
				bar_queue.push_back(make_bar(rand_price(), rand_price(), rand_price(),
					$urandom_range(19) == 0));
			else
				bar_queue.push_back(make_bar(base + $urandom_range(32'h0003_0000),
					base - $urandom_range(32'h0003_0000), base ^ $urandom_range(32'hFFFF),
					$urandom_range(199) == 0));
			if ($urandom_range(15) == 0) base = $urandom;
		end
	endtask

	// Stimulus
	initial begin
		cur_period = 20;
		restart_series();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: periods 1, 2, 0 and 127, extremes, flat window, saturation
		write_period(1);
		bar_queue.push_back(make_bar(32'h0, 32'h0, 32'h0, 1'b0));
		bar_queue.push_back(make_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
		drain();
		write_period(2);
		bar_queue.push_back(make_bar(32'h0, 32'h0, 32'h0, 1'b1));
		bar_queue.push_back(make_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
		bar_queue.push_back(make_bar(32'h0, 32'h0, 32'h0, 1'b0));
		bar_queue.push_back(make_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'h1, 1'b0));
		bar_queue.push_back(make_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'h1, 1'b0));
		bar_queue.push_back(make_bar(32'h0001_0000, 32'h0, 32'h0, 1'b1));
		for (int i = 0; i < 6; i++)
			bar_queue.push_back(make_bar(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0));
		drain();
		write_period(0);
		bar_queue.push_back(make_bar(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 1'b0));
		bar_queue.push_back(make_bar(32'h1, 32'h0, 32'h0, 1'b1));
		drain();
		write_period(127);
		for (int i = 0; i < 130; i++)
			bar_queue.push_back(make_bar(32'h0010_0000, 32'h0010_0000, 32'h0010_0000,
				1'b0));
		bar_queue.push_back(make_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
		drain();

		// Random: receiver idles more first, then sender, then neither
		send_idle_pct = 25;
		recv_idle_pct = 65;
		write_period(3);
		random_bars(250);
		hold_off = 3000;
		drain();
		send_idle_pct = 65;
		recv_idle_pct = 25;
		write_period(64);
		random_bars(200);
		drain();
		write_period(20);
		random_bars(250);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_period(7);
		random_bars(250);
		drain();
		write_period($urandom_range(1, 64));
		random_bars(100);
		drain();

		$display("bars %0d, results %0d (flat %0d, saturated %0d)",
			bars_sent, results_seen, flat_seen, sat_seen);
		$display("periods 0,1,2,3,7,20,64,127 and a random one; mismatches %0d", errors);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ----- sim.f -----
src/cci_pkg.sv
src/cci_cell.sv
src/cci_ring.sv
src/cci_div.sv
src/commodity_channel_index.sv
dv/tb_top.sv
